@@ rtl/vtp_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex transform package
// Widths, codes, command and result types, and fixed-point helpers shared by
// the vertex transform and projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int IO_BITS   = 32;
  localparam int VD_W      = 15;
  localparam int CO_W      = 12;
  localparam int ANG_W     = 10;
  localparam int KIND_W    = 3;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 1;

  // Accumulator and saturation headroom.
  localparam int EXT_W    = ((WORD_BITS > IO_BITS) ? WORD_BITS : IO_BITS) + 3;
  // Signed product of a matrix coordinate and the view distance.
  localparam int NUM_W    = WORD_BITS + VD_W + 1;
  // Magnitude of the scaled numerator fed to the divider.
  localparam int NUM_BITS = WORD_BITS + VD_W + FRAC_BITS;
  // Signed denominator depth plus view distance.
  localparam int DEN_W    = ((WORD_BITS > VD_W + FRAC_BITS + 1) ?
                             WORD_BITS : VD_W + FRAC_BITS + 1) + 1;
  // Projection sum width.
  localparam int PRJ_W    = ((CO_W + FRAC_BITS + 1 > IO_BITS + 2) ?
                             CO_W + FRAC_BITS + 1 : IO_BITS + 2) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [VD_W-1:0] VD_RESET = VD_W'(500);
  localparam logic [CO_W-1:0] CO_RESET = CO_W'(300);

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_IDENT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPOSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VERTEX  = 2'd2;

  // Elementary transform codes.
  localparam logic [KIND_W-1:0] KIND_TRANS   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ROT_X   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ROT_Y   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ROT_Z   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SHEAR_X = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SHEAR_Y = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SHEAR_Z = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SCALE   = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'd1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [IO_BITS-1:0]   io_t;

  localparam word_t Q_ONE = word_t'(1) <<< FRAC_BITS;

  typedef enum logic [1:0] {
    OP_IDENT,
    OP_COMPOSE,
    OP_VERTEX
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [KIND_W-1:0]  kind;
    word_t              sin_v;
    word_t              cos_v;
    word_t              arg_x;
    word_t              arg_y;
    word_t              arg_z;
  } cmd_t;

  typedef struct packed {
    io_t  screen_x;
    io_t  screen_y;
    io_t  depth;
    logic div_fault;
  } res_t;

  typedef logic [90:0][FRAC_BITS:0] sin_tab_t;

  // Saturate a wide signed value to the matrix word.
  function automatic word_t sat_word(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    logic signed [EXT_W-1:0] r;
    hi = (EXT_W'(1) <<< (WORD_BITS - 1)) - EXT_W'(1);
    lo = -hi - EXT_W'(1);
    r  = v;
    if (v > hi) r = hi;
    if (v < lo) r = lo;
    return word_t'(r);
  endfunction

  // Round a product magnitude to nearest (ties away from zero), saturate, sign.
  function automatic word_t mulq_term(input logic [2*WORD_BITS-1:0] p,
                                      input logic neg);
    logic [2*WORD_BITS:0]           t;
    logic [2*WORD_BITS-FRAC_BITS:0] r;
    logic [WORD_BITS-1:0]           lim;
    logic [WORD_BITS-1:0]           m;
    t   = {1'b0, p} + ((2*WORD_BITS+1)'(1) << (FRAC_BITS - 1));
    r   = t[2*WORD_BITS:FRAC_BITS];
    lim = {1'b0, {(WORD_BITS-1){1'b1}}} + WORD_BITS'(neg);
    if (r > (2*WORD_BITS-FRAC_BITS+1)'(lim)) m = lim;
    else m = r[WORD_BITS-1:0];
    return neg ? word_t'(-m) : word_t'(m);
  endfunction

  // Sine of a whole degree in 0..90, Taylor series in Q30, rounded to Q.FRAC.
  function automatic logic [FRAC_BITS:0] sin_deg(input int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    x    = (64'(k) * 64'd3373259426 + 64'd90) / 64'd180;
    term = x;
    sum  = longint'(x);
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd6;
    sum  = sum - longint'(term);
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd20;
    sum  = sum + longint'(term);
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd42;
    sum  = sum - longint'(term);
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd72;
    sum  = sum + longint'(term);
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd110;
    sum  = sum - longint'(term);
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    return (FRAC_BITS+1)'((sum + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int i = 0; i <= 90; i++) begin
      t[i] = sin_deg(i);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

`default_nettype wire

@@ rtl/vtp_front.sv @@
// ----------------------------------------------------------------------------
// Vertex transform front end
// Accepts requests, drops unused modes, saturates operands and looks up the
// sine and cosine of the rotation angle, then queues a command.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_front (
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [vtp_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [vtp_pkg::KIND_W-1:0]   kind_i,
  input  wire logic signed [vtp_pkg::ANG_W-1:0] angle_deg_i,
  input  wire logic signed [vtp_pkg::IO_BITS-1:0] arg_x_i,
  input  wire logic signed [vtp_pkg::IO_BITS-1:0] arg_y_i,
  input  wire logic signed [vtp_pkg::IO_BITS-1:0] arg_z_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output vtp_pkg::cmd_t                     q_cmd_o
);
  import vtp_pkg::*;

  logic signed [ANG_W:0] ang_w;
  logic [8:0]            deg;
  logic [8:0]            s_idx;
  logic [8:0]            c_idx;
  logic                  s_neg;
  logic                  c_neg;
  word_t                 s_mag;
  word_t                 c_mag;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i &&
                      (mode_i == MODE_IDENT || mode_i == MODE_COMPOSE ||
                       mode_i == MODE_VERTEX);

  // Reduce the angle into 0..359 and fold it into the first quadrant.
  always_comb begin
    ang_w = (ANG_W+1)'(angle_deg_i);
    if (ang_w < 0) ang_w = ang_w + (ANG_W+1)'(360);
    if (ang_w < 0) ang_w = ang_w + (ANG_W+1)'(360);
    if (ang_w >= (ANG_W+1)'(360)) ang_w = ang_w - (ANG_W+1)'(360);
    deg = ang_w[8:0];
    if (deg <= 9'd90) begin
      s_idx = deg;           s_neg = 1'b0;
      c_idx = 9'd90 - deg;   c_neg = 1'b0;
    end else if (deg <= 9'd180) begin
      s_idx = 9'd180 - deg;  s_neg = 1'b0;
      c_idx = deg - 9'd90;   c_neg = 1'b1;
    end else if (deg <= 9'd270) begin
      s_idx = deg - 9'd180;  s_neg = 1'b1;
      c_idx = 9'd270 - deg;  c_neg = 1'b1;
    end else begin
      s_idx = 9'd360 - deg;  s_neg = 1'b1;
      c_idx = deg - 9'd270;  c_neg = 1'b0;
    end
    s_mag = word_t'(SIN_TAB[s_idx[6:0]]);
    c_mag = word_t'(SIN_TAB[c_idx[6:0]]);
  end

  always_comb begin
    case (mode_i)
      MODE_IDENT:   q_cmd_o.op = OP_IDENT;
      MODE_COMPOSE: q_cmd_o.op = OP_COMPOSE;
      default:      q_cmd_o.op = OP_VERTEX;
    endcase
    q_cmd_o.kind  = kind_i;
    q_cmd_o.sin_v = s_neg ? -s_mag : s_mag;
    q_cmd_o.cos_v = c_neg ? -c_mag : c_mag;
    q_cmd_o.arg_x = sat_word(EXT_W'(arg_x_i));
    q_cmd_o.arg_y = sat_word(EXT_W'(arg_y_i));
    q_cmd_o.arg_z = sat_word(EXT_W'(arg_z_i));
  end

endmodule

`default_nettype wire

@@ rtl/vtp_fifo.sv @@
// ----------------------------------------------------------------------------
// Vertex transform command queue
// Short queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire vtp_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output vtp_pkg::cmd_t      head_o
);
  import vtp_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/vtp_div.sv @@
// ----------------------------------------------------------------------------
// Vertex transform serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [vtp_pkg::NUM_BITS-1:0]  dividend_i,
  input  wire logic [vtp_pkg::DEN_W-1:0]     divisor_i,
  output logic [vtp_pkg::NUM_BITS-1:0]       quot_o,
  output logic                               done_o
);
  import vtp_pkg::*;

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] dvd_q;
  logic [DEN_W-1:0]    dvs_q;
  logic [DEN_W-1:0]    rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                done_q;
  logic [DEN_W:0]      rem_sh;
  logic                q_bit;
  logic [DEN_W:0]      rem_sub;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[NUM_BITS-1]};
    q_bit   = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_BITS);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  // The dividend register shifts out its top bit and takes the quotient bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[NUM_BITS-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/vtp_back.sv @@
// ----------------------------------------------------------------------------
// Vertex transform back end
// Holds the matrix, runs the shared multiply-accumulate sequencer and the
// perspective divide, and keeps the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_empty_i,
  input  wire vtp_pkg::cmd_t            q_head_i,
  output logic                          q_pop_o,
  input  wire logic [vtp_pkg::VD_W-1:0] view_i,
  input  wire logic [vtp_pkg::CO_W-1:0] offset_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output vtp_pkg::res_t                 res_o
);
  import vtp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_NUM,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e      state_q;
  word_t       mat_q [3][4];
  word_t       nm_q  [3][4];
  word_t       vtx_q [3];
  cmd_t        cmd_q;
  logic [1:0]  ri_q, cj_q, st_q;
  logic        out_valid_q;
  logic        fault_q;
  res_t        res_q;

  logic [2*WORD_BITS-1:0]  prod_q;
  logic                    pneg_q;
  logic signed [EXT_W-1:0] acc_q;
  logic signed [NUM_W-1:0] num_x_q, num_y_q;
  logic signed [DEN_W-1:0] den_q;

  logic                    is_vtx;
  word_t                   a_op, b_op, base, term, res_w;
  logic [WORD_BITS-1:0]    a_mag, b_mag;
  logic                    out_free;
  logic                    div_start;
  logic [NUM_BITS-1:0]     quot_x, quot_y;
  logic                    done_x, done_y;
  logic [NUM_W-1:0]        nmag_x, nmag_y;
  logic [DEN_W-1:0]        dmag;
  io_t                     sx, sy;

  function automatic word_t arg_sel(input cmd_t c, input logic [1:0] k);
    word_t r;
    case (k)
      2'd0:    r = c.arg_x;
      2'd1:    r = c.arg_y;
      default: r = c.arg_z;
    endcase
    return r;
  endfunction

  // Entry k,j of the elementary transform (identity based).
  function automatic word_t e_entry(input cmd_t c, input logic [1:0] k,
                                    input logic [1:0] j);
    word_t e;
    e = (k == j) ? Q_ONE : '0;
    case (c.kind)
      KIND_TRANS: begin
        if (j == 2'd3) e = arg_sel(c, k);
      end
      KIND_ROT_X: begin
        if (k == 2'd1 && j == 2'd1) e = c.cos_v;
        if (k == 2'd1 && j == 2'd2) e = -c.sin_v;
        if (k == 2'd2 && j == 2'd1) e = c.sin_v;
        if (k == 2'd2 && j == 2'd2) e = c.cos_v;
      end
      KIND_ROT_Y: begin
        if (k == 2'd0 && j == 2'd0) e = c.cos_v;
        if (k == 2'd0 && j == 2'd2) e = c.sin_v;
        if (k == 2'd2 && j == 2'd0) e = -c.sin_v;
        if (k == 2'd2 && j == 2'd2) e = c.cos_v;
      end
      KIND_ROT_Z: begin
        if (k == 2'd0 && j == 2'd0) e = c.cos_v;
        if (k == 2'd0 && j == 2'd1) e = -c.sin_v;
        if (k == 2'd1 && j == 2'd0) e = c.sin_v;
        if (k == 2'd1 && j == 2'd1) e = c.cos_v;
      end
      KIND_SHEAR_X: begin
        if (k == 2'd1 && j == 2'd0) e = c.arg_y;
        if (k == 2'd2 && j == 2'd0) e = c.arg_z;
      end
      KIND_SHEAR_Y: begin
        if (k == 2'd0 && j == 2'd1) e = c.arg_x;
        if (k == 2'd2 && j == 2'd1) e = c.arg_z;
      end
      KIND_SHEAR_Z: begin
        if (k == 2'd0 && j == 2'd2) e = c.arg_x;
        if (k == 2'd1 && j == 2'd2) e = c.arg_y;
      end
      default: begin
        if (k == j && j != 2'd3) e = arg_sel(c, k);
      end
    endcase
    return e;
  endfunction

  function automatic logic signed [PRJ_W-1:0] clamp_prj(
      input logic signed [PRJ_W-1:0] v);
    logic signed [PRJ_W-1:0] hi;
    logic signed [PRJ_W-1:0] r;
    hi = (PRJ_W'(1) <<< (IO_BITS - 1)) - PRJ_W'(1);
    r  = v;
    if (v > hi) r = hi;
    if (v < -hi - PRJ_W'(1)) r = -hi - PRJ_W'(1);
    return r;
  endfunction

  function automatic io_t clamp_depth(input word_t v);
    logic signed [EXT_W-1:0] w;
    logic signed [EXT_W-1:0] hi;
    w  = EXT_W'(v);
    hi = (EXT_W'(1) <<< (IO_BITS - 1)) - EXT_W'(1);
    if (w > hi) w = hi;
    if (w < -hi - EXT_W'(1)) w = -hi - EXT_W'(1);
    return io_t'(w);
  endfunction

  // Truncated quotient, clamped to 2^IO_BITS, signed, saturated, plus offset.
  function automatic io_t project(input logic [NUM_BITS-1:0] q, input logic neg,
                                  input logic [CO_W-1:0] co);
    logic [IO_BITS:0]        qc;
    logic signed [PRJ_W-1:0] qs;
    if (q > (NUM_BITS'(1) << IO_BITS)) qc = {1'b1, IO_BITS'(0)};
    else qc = q[IO_BITS:0];
    qs = PRJ_W'({1'b0, qc});
    if (neg) qs = -qs;
    qs = clamp_prj(qs);
    qs = clamp_prj(qs + (PRJ_W'(co) <<< FRAC_BITS));
    return io_t'(qs);
  endfunction

  assign is_vtx   = (cmd_q.op == OP_VERTEX);
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    a_op  = mat_q[ri_q][st_q];
    b_op  = is_vtx ? arg_sel(cmd_q, st_q) : e_entry(cmd_q, st_q, cj_q);
    base  = (is_vtx || cj_q == 2'd3) ? mat_q[ri_q][3] : '0;
    a_mag = a_op[WORD_BITS-1] ? WORD_BITS'(-a_op) : WORD_BITS'(a_op);
    b_mag = b_op[WORD_BITS-1] ? WORD_BITS'(-b_op) : WORD_BITS'(b_op);
    term  = mulq_term(prod_q, pneg_q);
    res_w = sat_word(acc_q + EXT_W'(term));
  end

  always_comb begin
    nmag_x = num_x_q[NUM_W-1] ? NUM_W'(-num_x_q) : NUM_W'(num_x_q);
    nmag_y = num_y_q[NUM_W-1] ? NUM_W'(-num_y_q) : NUM_W'(num_y_q);
    dmag   = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
    sx     = project(quot_x, num_x_q[NUM_W-1] ^ den_q[DEN_W-1], offset_i);
    sy     = project(quot_y, num_y_q[NUM_W-1] ^ den_q[DEN_W-1], offset_i);
  end

  assign div_start = (state_q == ST_LOAD) && (den_q != '0);

  vtp_div u_div_x (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i ({nmag_x[WORD_BITS+VD_W-1:0], FRAC_BITS'(0)}),
    .divisor_i  (dmag),
    .quot_o     (quot_x),
    .done_o     (done_x)
  );

  vtp_div u_div_y (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i ({nmag_y[WORD_BITS+VD_W-1:0], FRAC_BITS'(0)}),
    .divisor_i  (dmag),
    .quot_o     (quot_y),
    .done_o     (done_y)
  );

  // Sequencer, matrix and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ri_q        <= '0;
      cj_q        <= '0;
      st_q        <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          mat_q[i][j] <= (i == j) ? Q_ONE : '0;
        end
      end
    end else begin
      // The finish state reloads the valid itself whenever the output is free.
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            ri_q <= '0;
            cj_q <= '0;
            st_q <= '0;
            if (q_head_i.op == OP_IDENT) begin
              for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 4; j++) begin
                  mat_q[i][j] <= (i == j) ? Q_ONE : '0;
                end
              end
            end else begin
              state_q <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          st_q <= st_q + 1'b1;
          if (st_q == 2'd3) begin
            if (is_vtx) begin
              ri_q <= ri_q + 1'b1;
              if (ri_q == 2'd2) state_q <= ST_NUM;
            end else begin
              cj_q <= cj_q + 1'b1;
              if (cj_q == 2'd3) begin
                ri_q <= ri_q + 1'b1;
                if (ri_q == 2'd2) begin
                  // The last entry is still on the accumulator output.
                  for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 4; j++) begin
                      if (i == 2 && j == 3) mat_q[i][j] <= res_w;
                      else mat_q[i][j] <= nm_q[i][j];
                    end
                  end
                  state_q <= ST_IDLE;
                end
              end
            end
          end
        end
        ST_NUM:  state_q <= ST_LOAD;
        ST_LOAD: state_q <= (den_q == '0) ? ST_FIN : ST_DIV;
        ST_DIV: begin
          if (done_x && done_y) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_head_i;
    prod_q <= a_mag * b_mag;
    pneg_q <= a_op[WORD_BITS-1] ^ b_op[WORD_BITS-1];
    if (state_q == ST_MAC) begin
      if (st_q == 2'd0) acc_q <= EXT_W'(base);
      else acc_q <= acc_q + EXT_W'(term);
      if (st_q == 2'd3) begin
        if (is_vtx) vtx_q[ri_q] <= res_w;
        else nm_q[ri_q][cj_q] <= res_w;
      end
    end
    if (state_q == ST_NUM) begin
      num_x_q <= NUM_W'(vtx_q[0]) * NUM_W'(signed'({1'b0, view_i}));
      num_y_q <= NUM_W'(vtx_q[1]) * NUM_W'(signed'({1'b0, view_i}));
      den_q   <= DEN_W'(vtx_q[2]) + (DEN_W'(view_i) <<< FRAC_BITS);
    end
    if (state_q == ST_LOAD) fault_q <= (den_q == '0);
    if (state_q == ST_FIN && out_free) begin
      res_q.screen_x  <= fault_q ? '0 : sx;
      res_q.screen_y  <= fault_q ? '0 : sy;
      res_q.depth     <= clamp_depth(vtx_q[2]);
      res_q.div_fault <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/vertex_transform_projection.sv @@
// ----------------------------------------------------------------------------
// Vertex transform and perspective projection
// Affine 3x4 Q16.16 transform with elementary composition and a projecting
// vertex path behind a valid/stall request interface.
// ----------------------------------------------------------------------------
// A mode 0 request reloads the identity, a mode 1 request post-multiplies the
// matrix by a translation, rotation, shear or scale, and a mode 2 request
// transforms a vertex and returns one result with depth and the projected
// screen coordinates; mode 3 is dropped. Requests enter a two-deep command
// queue, so the input side keeps accepting until the queue is full while the
// back end works and while a finished result waits in the output register.
// The back end works on one command at a time. A compose request passes
// every one of the twelve matrix entries through the single shared multiplier
// as three products and a rounding, saturating accumulate. A vertex request
// runs the three coordinate rows through the multiplier, forms the numerators
// and the denominator, then starts the two bit-serial restoring dividers,
// which produce one quotient bit per cycle and run side by side for x and y.
// When depth plus view distance is zero the divide is skipped, the fault
// flag is set and both screen coordinates are zero. Configuration writes are
// expected only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_projection (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [vtp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [vtp_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [vtp_pkg::MODE_W-1:0]         mode_i,
  input  wire logic [vtp_pkg::KIND_W-1:0]         kind_i,
  input  wire logic signed [vtp_pkg::ANG_W-1:0]   angle_deg_i,
  input  wire logic signed [vtp_pkg::IO_BITS-1:0] arg_x_i,
  input  wire logic signed [vtp_pkg::IO_BITS-1:0] arg_y_i,
  input  wire logic signed [vtp_pkg::IO_BITS-1:0] arg_z_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [vtp_pkg::IO_BITS-1:0]      screen_x_o,
  output logic signed [vtp_pkg::IO_BITS-1:0]      screen_y_o,
  output logic signed [vtp_pkg::IO_BITS-1:0]      depth_o,
  output logic                                    div_fault_o
);
  import vtp_pkg::*;

  logic [VD_W-1:0] view_q;
  logic [CO_W-1:0] offset_q;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_cmd, q_head;
  res_t res;

  // Configuration registers; writes take effect at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q   <= VD_RESET;
      offset_q <= CO_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIEW:   view_q   <= cfg_wdata_i[VD_W-1:0];
        CFG_OFFSET: offset_q <= cfg_wdata_i[CO_W-1:0];
        default:    view_q   <= view_q;
      endcase
    end
  end

  // The front end classifies the request and prepares its operands.
  vtp_front u_front (
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .kind_i,
    .angle_deg_i,
    .arg_x_i,
    .arg_y_i,
    .arg_z_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd)
  );

  // The queue decouples the front end from the long back end operations.
  vtp_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // The back end owns the matrix, the multiplier and the dividers.
  vtp_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .view_i      (view_q),
    .offset_i    (offset_q),
    .out_valid_o,
    .out_stall_i,
    .res_o       (res)
  );

  assign screen_x_o  = res.screen_x;
  assign screen_y_o  = res.screen_y;
  assign depth_o     = res.depth;
  assign div_fault_o = res.div_fault;

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("command queue written while full");

  // The back end only takes a command that is present.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command queue read while empty");

  // A faulted projection reports zero screen coordinates.
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_fault_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("fault result with nonzero coordinates");

endmodule

`default_nettype wire
